FILE: rtl/sorted_schedule_interval_lookup_assert.svh
// Assertion macros for the schedule lookup block.
// No dependencies; taken in by `include inside the module body.
`ifndef SORTED_SCHEDULE_INTERVAL_LOOKUP_ASSERT_SVH
`define SORTED_SCHEDULE_INTERVAL_LOOKUP_ASSERT_SVH

// same-cycle implication
`define SSIL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSIL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ssil_pkg.sv
// Types, status/operation codes and the HHMM legality check for the
// schedule lookup block. No dependencies.
package ssil_pkg;

  localparam int TIME_W   = 12;
  localparam int ID_W     = 8;
  localparam int STATUS_W = 3;

  typedef logic [TIME_W-1:0]   hhmm_t;
  typedef logic [ID_W-1:0]     act_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam status_t ST_ADDED     = 3'd0;
  localparam status_t ST_ILLEGAL   = 3'd1;
  localparam status_t ST_DUPLICATE = 3'd2;
  localparam status_t ST_FULL      = 3'd3;
  localparam status_t ST_FOUND     = 3'd4;
  localparam status_t ST_FREE      = 3'd5;

  localparam int MAX_TIME   = 2359;
  localparam int HHMM_SCALE = 100;
  localparam int MAX_MINUTE = 59;
  localparam int HOURS      = MAX_TIME / HHMM_SCALE + 1;

  // legal when the value falls in [h00, h59] for some hour h
  function automatic logic time_legal(input hhmm_t t);
    logic ok;
    ok = 1'b0;
    for (int h = 0; h < HOURS; h++) begin
      if (t >= hhmm_t'(h * HHMM_SCALE) && t <= hhmm_t'(h * HHMM_SCALE + MAX_MINUTE)) begin
        ok = 1'b1;
      end
    end
    return ok;
  endfunction

endpackage

FILE: rtl/sorted_schedule_interval_lookup.sv
// Sorted schedule table with predecessor lookup; uses ssil_pkg and the assert header.
// Result strobed on done after the input register and then the result register.
// Throughput: one request per cycle; busy is low except during and right after reset.
// Table is a shift line of TABLE_DEPTH registers compared in parallel against the request.
// Reset (rst, synchronous) empties the table; entry contents are not cleared.
module sorted_schedule_interval_lookup #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   operation,
  input  ssil_pkg::hhmm_t        time_hhmm,
  input  ssil_pkg::act_t         activity_id,
  output logic                   done,
  output ssil_pkg::status_t      status,
  output ssil_pkg::act_t         found_activity,
  output ssil_pkg::hhmm_t        period_start,
  output ssil_pkg::hhmm_t        period_end
);
  import ssil_pkg::*;

  `include "sorted_schedule_interval_lookup_assert.svh"

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // input stage
  logic  req_valid;
  logic  req_op;
  hhmm_t req_time;
  act_t  req_id;
  logic  req_legal;

  // table
  hhmm_t            start_times [TABLE_DEPTH];
  act_t             activity_ids[TABLE_DEPTH];
  hhmm_t            st_prev     [TABLE_DEPTH];
  act_t             id_prev     [TABLE_DEPTH];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic [TABLE_DEPTH-1:0] valid;
  logic [TABLE_DEPTH-1:0] lt;
  logic [TABLE_DEPTH-1:0] le;
  logic [TABLE_DEPTH-1:0] eq;
  logic [TABLE_DEPTH-1:0] lt_lo;
  logic [TABLE_DEPTH-1:0] le_lo;
  logic [TABLE_DEPTH-1:0] le_hi;
  logic [TABLE_DEPTH-1:0] sel;
  logic [TABLE_DEPTH-1:0] nxt;

  logic    dup;
  logic    full;
  logic    do_insert;
  act_t    sel_id;
  hhmm_t   sel_start;
  hhmm_t   nxt_start;
  status_t status_next;
  act_t    act_next;
  hhmm_t   pstart_next;
  hhmm_t   pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      req_valid <= 1'b0;
    end else begin
      busy      <= 1'b0;
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_op    <= operation;
      req_time  <= time_hhmm;
      req_id    <= activity_id;
      req_legal <= time_legal(time_hhmm);
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      valid[i] = CNT_W'(i) < count;
      lt[i]    = valid[i] && (start_times[i] < req_time);
      le[i]    = valid[i] && (start_times[i] <= req_time);
      eq[i]    = valid[i] && (start_times[i] == req_time);
    end
    st_prev[0] = '0;
    id_prev[0] = '0;
    for (int i = 1; i < TABLE_DEPTH; i++) begin
      st_prev[i] = start_times[i-1];
      id_prev[i] = activity_ids[i-1];
    end
  end

  // lt and le are thermometer codes since the table is sorted
  assign lt_lo = {lt[TABLE_DEPTH-2:0], 1'b1};
  assign le_lo = {le[TABLE_DEPTH-2:0], 1'b1};
  assign le_hi = {1'b0, le[TABLE_DEPTH-1:1]};
  assign sel   = le & ~le_hi;
  assign nxt   = valid & ~le & le_lo;

  always_comb begin
    sel_id    = '0;
    sel_start = '0;
    nxt_start = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sel_id    = sel_id | ({ID_W{sel[i]}} & activity_ids[i]);
      sel_start = sel_start | ({TIME_W{sel[i]}} & start_times[i]);
      nxt_start = nxt_start | ({TIME_W{nxt[i]}} & start_times[i]);
    end
  end

  assign dup  = |eq;
  assign full = count == CNT_W'(TABLE_DEPTH);

  always_comb begin
    status_next = ST_FREE;
    act_next    = '0;
    pstart_next = '0;
    pend_next   = '0;
    do_insert   = 1'b0;
    priority if (!req_legal) begin
      status_next = ST_ILLEGAL;
    end else if (req_op == OP_ADD) begin
      priority if (dup) begin
        status_next = ST_DUPLICATE;
      end else if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_ADDED;
        do_insert   = req_valid;
      end
    end else if (le[0]) begin
      status_next = ST_FOUND;
      act_next    = sel_id;
      pstart_next = sel_start;
      pend_next   = nxt_start;
    end else begin
      status_next = ST_FREE;
      pend_next   = nxt_start;
    end
  end

  assign count_next = do_insert ? count + CNT_W'(1) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= req_valid;
    end
  end

  // insert: entries below the slot hold, the slot takes the request, the rest shift up
  always_ff @(posedge clk) begin
    if (do_insert) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (!lt[i]) begin
          if (lt_lo[i]) begin
            start_times[i]  <= req_time;
            activity_ids[i] <= req_id;
          end else begin
            start_times[i]  <= st_prev[i];
            activity_ids[i] <= id_prev[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      status         <= status_next;
      found_activity <= act_next;
      period_start   <= pstart_next;
      period_end     <= pend_next;
    end
  end

  `SSIL_ASSERT_IMP(a_count_max, clk, rst, 1'b1, count <= CNT_W'(TABLE_DEPTH), "entry count above depth")
  `SSIL_ASSERT_IMP(a_done_latency, clk, rst, start && !busy, ##2 done, "request without result")
  `SSIL_ASSERT_IMP(a_added_count, clk, rst, done && status == ST_ADDED, count == $past(count) + CNT_W'(1), "add without count step")
  `SSIL_ASSERT_NXT(a_illegal_hold, clk, rst, req_valid && !req_legal, count == $past(count), "illegal request changed table")

endmodule

FILE: test/schedule_lookup_checker.sv
`timescale 1ns / 1ps
// Checker for sorted_schedule_interval_lookup: watches request and result ports,
// keeps its own sorted schedule, predicts each result and compares. Uses ssil_pkg.
module schedule_lookup_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 operation,
  input  ssil_pkg::hhmm_t      time_hhmm,
  input  ssil_pkg::act_t       activity_id,
  input  logic                 done,
  input  ssil_pkg::status_t    status,
  input  ssil_pkg::act_t       found_activity,
  input  ssil_pkg::hhmm_t      period_start,
  input  ssil_pkg::hhmm_t      period_end,
  output int                   pending,
  output int                   fail_count
);
  import ssil_pkg::*;

  typedef struct {
    status_t status;
    act_t    activity;
    hhmm_t   p_start;
    hhmm_t   p_end;
  } slot_answer_t;

  hhmm_t        sched_start [TABLE_DEPTH];
  act_t         sched_act   [TABLE_DEPTH];
  int           sched_count = 0;
  slot_answer_t answers_due [$];

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic slot_answer_t schedule_request(input logic op, input hhmm_t t,
                                                    input act_t id);
    slot_answer_t r;
    int pos;
    int k;
    r = '{status: ST_ILLEGAL, activity: '0, p_start: '0, p_end: '0};
    if (!(t <= MAX_TIME && (t % HHMM_SCALE) <= MAX_MINUTE)) begin
      r.status = ST_ILLEGAL;
    end else if (op == OP_ADD) begin
      pos = sched_count;
      for (int i = 0; i < sched_count; i++) begin
        if (sched_start[i] >= t) begin
          pos = i;
          break;
        end
      end
      if (pos < sched_count && sched_start[pos] == t) begin
        r.status = ST_DUPLICATE;
      end else if (sched_count >= TABLE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        for (int i = sched_count; i > pos; i--) begin
          sched_start[i] = sched_start[i-1];
          sched_act[i]   = sched_act[i-1];
        end
        sched_start[pos] = t;
        sched_act[pos]   = id;
        sched_count++;
        r.status = ST_ADDED;
      end
    end else if (sched_count == 0) begin
      r.status = ST_FREE;
    end else if (t < sched_start[0]) begin
      r.status = ST_FREE;
      r.p_end  = sched_start[0];
    end else begin
      k = 0;
      for (int i = 0; i < sched_count; i++) begin
        if (sched_start[i] <= t) k = i;
      end
      r.status   = ST_FOUND;
      r.activity = sched_act[k];
      r.p_start  = sched_start[k];
      r.p_end    = (k + 1 < sched_count) ? sched_start[k+1] : '0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    slot_answer_t want;
    if (rst) begin
      sched_count = 0;
      answers_due.delete();
      pending <= 0;
    end else begin
      if (done) begin
        if (answers_due.size() == 0) begin
          report($sformatf("result with no request outstanding, status %0d", status));
        end else begin
          want = answers_due.pop_front();
          if (status !== want.status)
            report($sformatf("status got %0d expected %0d", status, want.status));
          if (found_activity !== want.activity)
            report($sformatf("found_activity got %0d expected %0d",
                             found_activity, want.activity));
          if (period_start !== want.p_start)
            report($sformatf("period_start got %0d expected %0d",
                             period_start, want.p_start));
          if (period_end !== want.p_end)
            report($sformatf("period_end got %0d expected %0d", period_end, want.p_end));
        end
      end
      if (start && !busy)
        answers_due.push_back(schedule_request(operation, time_hhmm, activity_id));
      pending <= answers_due.size();
    end
  end

endmodule

FILE: test/tb_sorted_schedule_interval_lookup.sv
`timescale 1ns / 1ps
// Testbench top for sorted_schedule_interval_lookup: clock, reset, request stimulus
// and verdict. Depends on ssil_pkg, the block and schedule_lookup_checker.
module tb_sorted_schedule_interval_lookup;
  import ssil_pkg::*;

  localparam int DEPTH           = 64;
  localparam int IDLE_LIMIT      = 2000;
  localparam int RANDOM_REQUESTS = 1950;
  localparam int TIME_MAX_CODE   = 2**TIME_W - 1;

  logic    clk         = 1'b0;
  logic    rst         = 1'b1;
  logic    start       = 1'b0;
  logic    operation   = OP_ADD;
  hhmm_t   time_hhmm   = '0;
  act_t    activity_id = '0;
  logic    busy;
  logic    done;
  status_t status;
  act_t    found_activity;
  hhmm_t   period_start;
  hhmm_t   period_end;
  int      pending;
  int      fail_count;
  int      idle_cycles = 0;
  bit      gaps_on     = 1'b1;
  hhmm_t   tried_times [$];

  always #1 clk = ~clk;

  sorted_schedule_interval_lookup #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .time_hhmm(time_hhmm), .activity_id(activity_id),
    .done(done), .status(status), .found_activity(found_activity),
    .period_start(period_start), .period_end(period_end)
  );

  schedule_lookup_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .time_hhmm(time_hhmm), .activity_id(activity_id),
    .done(done), .status(status), .found_activity(found_activity),
    .period_start(period_start), .period_end(period_end),
    .pending(pending), .fail_count(fail_count)
  );

  // watchdog: cycles with neither a request taken nor a result
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL sorted_schedule_interval_lookup");
      $finish;
    end
  end

  task automatic issue(input logic op, input hhmm_t t, input act_t id);
    int gap;
    gap = gaps_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    operation   <= op;
    time_hhmm   <= t;
    activity_id <= id;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic hhmm_t any_legal();
    return hhmm_t'($urandom_range(0, HOURS - 1) * HHMM_SCALE
                   + $urandom_range(0, MAX_MINUTE));
  endfunction

  function automatic hhmm_t bad_time();
    if ($urandom_range(0, 1) == 0)
      return hhmm_t'($urandom_range(MAX_TIME + 1, TIME_MAX_CODE));
    return hhmm_t'($urandom_range(0, HOURS - 1) * HHMM_SCALE
                   + $urandom_range(MAX_MINUTE + 1, HHMM_SCALE - 1));
  endfunction

  function automatic hhmm_t pick_tried();
    if (tried_times.size() == 0) return any_legal();
    return tried_times[$urandom_range(0, tried_times.size() - 1)];
  endfunction

  initial begin
    int    roll;
    int    add_pct;
    hhmm_t t;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed requests
    issue(OP_LOOKUP, hhmm_t'(1200), 8'h11);
    issue(OP_LOOKUP, hhmm_t'(2360), 8'h00);
    issue(OP_ADD,    hhmm_t'(TIME_MAX_CODE), 8'hFF);
    issue(OP_ADD,    hhmm_t'(60),   8'h01);
    issue(OP_LOOKUP, hhmm_t'(99),   8'h02);
    issue(OP_ADD,    hhmm_t'(2400), 8'h03);
    issue(OP_ADD,    hhmm_t'(1200), 8'hA5);
    issue(OP_LOOKUP, hhmm_t'(1159), 8'h00);
    issue(OP_LOOKUP, hhmm_t'(1200), 8'hFF);
    issue(OP_ADD,    hhmm_t'(1200), 8'h5A);
    issue(OP_ADD,    hhmm_t'(0),    8'h00);
    issue(OP_ADD,    hhmm_t'(2359), 8'hFF);
    issue(OP_ADD,    hhmm_t'(59),   8'h3C);
    issue(OP_LOOKUP, hhmm_t'(0),    8'h00);
    issue(OP_LOOKUP, hhmm_t'(59),   8'h00);
    issue(OP_LOOKUP, hhmm_t'(100),  8'h00);
    issue(OP_LOOKUP, hhmm_t'(2358), 8'h00);
    issue(OP_LOOKUP, hhmm_t'(2359), 8'h00);
    issue(OP_ADD,    hhmm_t'(0),    8'h77);
    issue(OP_LOOKUP, hhmm_t'(1959), 8'hC3);
    tried_times = '{hhmm_t'(1200), hhmm_t'(0), hhmm_t'(2359), hhmm_t'(59)};
    drain();

    // random: sparse table first, then fill to full and keep probing
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if (n % 300 == 299) drain();
      add_pct = (n < 700) ? 6 : 30;
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < add_pct) begin
        if (roll < 10) begin
          t = bad_time();
        end else begin
          t = (roll < 25) ? pick_tried() : any_legal();
          tried_times.push_back(t);
        end
        issue(OP_ADD, t, act_t'($urandom_range(0, 255)));
      end else begin
        if (roll < 30) t = pick_tried();
        else if (roll < 50) t = ($urandom_range(0, 1) == 0) ? pick_tried() + 1'b1
                                                             : pick_tried() - 1'b1;
        else if (roll < 85) t = any_legal();
        else if (roll < 95) t = bad_time();
        else t = ($urandom_range(0, 1) == 0) ? hhmm_t'(0) : hhmm_t'(MAX_TIME);
        issue(OP_LOOKUP, t, act_t'($urandom_range(0, 255)));
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS sorted_schedule_interval_lookup");
    end else begin
      $display("FAIL sorted_schedule_interval_lookup");
    end
    $finish;
  end

endmodule
